@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tone curve RTL.
// Standalone header; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tce_pkg.sv @@
// Shared types, constants and fixed-point helpers for the tone curve evaluator.
// No dependencies.
`default_nettype none

package tce_pkg;

   typedef logic signed [23:0] fx_type;

   localparam int REG_IDX_W  = 3;
   localparam int DIV_STEPS  = 5;
   localparam int DIV_STAGES = 5;
   localparam int POW_SEGS   = 64;

   localparam logic [2:0] OP_LINEAR      = 3'd0;
   localparam logic [2:0] OP_REINHARD    = 3'd1;
   localparam logic [2:0] OP_REINHARD_EX = 3'd2;
   localparam logic [2:0] OP_HABLE       = 3'd3;
   localparam logic [2:0] OP_ACES        = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_TONE_OPERATOR   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_EXPOSURE_GAIN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WHITE_POINT     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EXPAND_STRENGTH = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CONTRAST_GAIN   = 3'd4;

   localparam fx_type FX_MAX  = 24'sh7FFFFF;
   localparam fx_type FX_MIN  = 24'sh800000;
   localparam fx_type FX_ONE  = 24'sd65536;
   localparam fx_type FX_HALF = 24'sd32768;
   localparam fx_type FX_ZERO = 24'sd0;

   localparam logic [15:0] K_EXP_MAX  = 16'd62259;
   localparam fx_type      DEN_MIN    = 24'sd7;
   localparam logic [15:0] CON_UNITY  = 16'd4096;

   localparam fx_type H_A = 24'sd9830;
   localparam fx_type H_B = 24'sd3277;
   localparam fx_type H_C = 24'sd262;
   localparam fx_type H_D = 24'sd3932;
   localparam fx_type H_E = 24'sd4369;

   localparam fx_type A_A = 24'sd164495;
   localparam fx_type A_B = 24'sd1966;
   localparam fx_type A_C = 24'sd159252;
   localparam fx_type A_D = 24'sd38666;
   localparam fx_type A_E = 24'sd9175;

   localparam logic [16:0] LIN_LIMIT = 17'd205;
   localparam fx_type LIN_GAIN = 24'sd846725;
   localparam fx_type ENC_GAIN = 24'sd69140;
   localparam fx_type ENC_OFS  = 24'sd3604;

   typedef struct packed {
      logic [23:0] rem;
      logic [24:0] quo;
      logic [24:0] dvd;
      logic [23:0] dsr;
      logic        neg;
      logic        zero;
      logic        ovf;
   } div_st_type;

   function automatic fx_type fx_sat(input logic signed [47:0] v);
      fx_type r;
      if (v > 48'sd8388607) r = FX_MAX;
      else if (v < -48'sd8388608) r = FX_MIN;
      else r = v[23:0];
      return r;
   endfunction

   function automatic fx_type fx_add(input fx_type a, input fx_type b);
      logic signed [47:0] s;
      s = {{24{a[23]}}, a} + {{24{b[23]}}, b};
      return fx_sat(s);
   endfunction

   // Product scaled by 2^-16, truncated toward zero.
   function automatic fx_type fx_mul(input fx_type a, input fx_type b);
      logic signed [47:0] ea;
      logic signed [47:0] eb;
      logic signed [47:0] p;
      logic signed [47:0] q;
      ea = {{24{a[23]}}, a};
      eb = {{24{b[23]}}, b};
      p  = ea * eb;
      q  = p >>> 16;
      if (p[47] && (p[15:0] != 16'd0)) q = q + 48'sd1;
      return fx_sat(q);
   endfunction

   // A few restoring division steps, one quotient bit each.
   function automatic div_st_type div_iter(input div_st_type s);
      div_st_type  t;
      logic [24:0] rr;
      t = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         rr    = {t.rem, t.dvd[24]};
         t.dvd = {t.dvd[23:0], 1'b0};
         if (rr >= {1'b0, t.dsr}) begin
            t.rem = 24'(rr - {1'b0, t.dsr});
            t.quo = {t.quo[23:0], 1'b1};
         end else begin
            t.rem = rr[23:0];
            t.quo = {t.quo[23:0], 1'b0};
         end
      end
      return t;
   endfunction

   // (i/64)^(1/2.4) in Q1.16: floor cube root, two floor square roots, round.
   function automatic logic [16:0] pow_entry(input int i);
      logic [63:0] n;
      logic [63:0] p5;
      logic [63:0] r;
      logic [63:0] c;
      logic [63:0] s1;
      logic [63:0] s2;
      n  = 64'(i);
      p5 = n * n * n * n * n;
      n  = p5 << 30;
      r  = 64'd0;
      for (int b = 20; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c * c <= n) r = c;
      end
      n = r << 20;
      r = 64'd0;
      for (int b = 21; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= n) r = c;
      end
      s1 = r;
      n  = s1 << 20;
      r  = 64'd0;
      for (int b = 21; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= n) r = c;
      end
      s2 = r;
      return 17'((s2 + 64'd8) >> 4);
   endfunction

endpackage

`default_nettype wire

@@ rtl/tce_div.sv @@
// Pipelined signed Q8.16 divider, (a*2^16)/b truncated and saturated.
// Uses tce_pkg; carries a side word alongside each quotient.
`default_nettype none

module tce_div #(
   parameter int SIDE_W = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire tce_pkg::fx_type     in_num,
   input  wire tce_pkg::fx_type     in_den,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output tce_pkg::fx_type          out_quo,
   output logic [SIDE_W-1:0]        out_side
);

   tce_pkg::div_st_type st_ff   [0:tce_pkg::DIV_STAGES];
   logic [SIDE_W-1:0]   side_ff [0:tce_pkg::DIV_STAGES];
   logic                vld_ff  [0:tce_pkg::DIV_STAGES];

   tce_pkg::div_st_type st_in;
   logic [23:0]         na;
   logic [23:0]         nb;

   tce_pkg::fx_type     quo_in;
   tce_pkg::fx_type     quo_ff;
   logic [SIDE_W-1:0]   oside_ff;
   logic                ovld_ff;

   always_comb begin
      na = in_num[23] ? 24'(~in_num + 24'd1) : in_num;
      nb = in_den[23] ? 24'(~in_den + 24'd1) : in_den;
      st_in.rem  = {9'd0, na[23:9]};
      st_in.quo  = 25'd0;
      st_in.dvd  = {na[8:0], 16'd0};
      st_in.dsr  = nb;
      st_in.neg  = in_num[23] ^ in_den[23];
      st_in.zero = (in_num == tce_pkg::FX_ZERO);
      // quotient needs more than 25 bits, or divisor is zero
      st_in.ovf  = ({9'd0, na} >= {nb, 9'd0});
   end

   always_comb begin
      if (st_ff[tce_pkg::DIV_STAGES].zero) begin
         quo_in = tce_pkg::FX_ZERO;
      end else if (st_ff[tce_pkg::DIV_STAGES].ovf) begin
         quo_in = st_ff[tce_pkg::DIV_STAGES].neg ? tce_pkg::FX_MIN : tce_pkg::FX_MAX;
      end else if (!st_ff[tce_pkg::DIV_STAGES].neg) begin
         quo_in = (st_ff[tce_pkg::DIV_STAGES].quo > 25'd8388607) ? tce_pkg::FX_MAX :
                  st_ff[tce_pkg::DIV_STAGES].quo[23:0];
      end else begin
         quo_in = (st_ff[tce_pkg::DIV_STAGES].quo > 25'd8388608) ? tce_pkg::FX_MIN :
                  24'(~st_ff[tce_pkg::DIV_STAGES].quo[23:0] + 24'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= tce_pkg::DIV_STAGES; k++) vld_ff[k] <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= tce_pkg::DIV_STAGES; k++) vld_ff[k] <= vld_ff[k-1];
         ovld_ff <= vld_ff[tce_pkg::DIV_STAGES];
      end
      if (adv) begin
         st_ff[0]   <= st_in;
         side_ff[0] <= in_side;
         for (int k = 1; k <= tce_pkg::DIV_STAGES; k++) begin
            st_ff[k]   <= tce_pkg::div_iter(st_ff[k-1]);
            side_ff[k] <= side_ff[k-1];
         end
         quo_ff   <= quo_in;
         oside_ff <= side_ff[tce_pkg::DIV_STAGES];
      end
   end

   assign out_valid = ovld_ff;
   assign out_quo   = quo_ff;
   assign out_side  = oside_ff;

endmodule

`default_nettype wire

@@ rtl/tce_srgb.sv @@
// sRGB encoder: linear segment or table-interpolated power, rounded to 8 bits.
// Uses tce_pkg; its last register is the result word register.
`default_nettype none

module tce_srgb (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire logic [16:0] in_level,
   output logic             out_valid,
   output logic [7:0]       out_code
);

   logic [16:0] pow_lut [0:tce_pkg::POW_SEGS];

   for (genvar g = 0; g <= tce_pkg::POW_SEGS; g++) begin : g_lut
      assign pow_lut[g] = tce_pkg::pow_entry(g);
   end

   logic [6:0]      idx;
   logic [9:0]      frac;
   logic [16:0]     lo;
   logic [16:0]     hi;
   logic [26:0]     span;
   logic [16:0]     pl_in;

   tce_pkg::fx_type lin_ff;
   logic [16:0]     pl_ff;
   logic            small_ff;
   logic            v1_ff;

   tce_pkg::fx_type enc_w;
   logic [16:0]     enc_in;
   logic [16:0]     enc_ff;
   logic            v2_ff;

   logic [24:0]     rnd;
   logic [7:0]      code_ff;
   logic            v3_ff;

   always_comb begin
      idx  = in_level[16:10];
      frac = in_level[9:0];
      lo   = pow_lut[idx];
      hi   = idx[6] ? lo : pow_lut[7'(idx + 7'd1)];
      if (hi < lo) hi = lo;
      span = 27'(hi - lo) * {17'd0, frac};
      // the full-scale level sits exactly on the last entry
      pl_in = idx[6] ? pow_lut[tce_pkg::POW_SEGS] : 17'(lo + span[26:10]);
   end

   always_comb begin
      enc_w = small_ff ? lin_ff :
              tce_pkg::fx_add(tce_pkg::fx_mul(tce_pkg::ENC_GAIN, {7'd0, pl_ff}),
                              24'(-tce_pkg::ENC_OFS));
      if (enc_w[23]) enc_in = 17'd0;
      else if (enc_w > tce_pkg::FX_ONE) enc_in = 17'd65536;
      else enc_in = enc_w[16:0];
   end

   assign rnd = {8'd0, enc_ff} * 25'd255 + 25'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         lin_ff   <= tce_pkg::fx_mul({7'd0, in_level}, tce_pkg::LIN_GAIN);
         pl_ff    <= pl_in;
         small_ff <= (in_level <= tce_pkg::LIN_LIMIT);
         enc_ff   <= enc_in;
         code_ff  <= rnd[23:16];
      end
   end

   assign out_valid = v3_ff;
   assign out_code  = code_ff;

endmodule

`default_nettype wire

@@ rtl/hdr_tone_curve_evaluator_core.sv @@
// Tone curve evaluator: one sample word in, one 8-bit sRGB word out.
// Throughput one word per cycle, except while a result waits on rsp_ready.
// Most of the depth comes from three dividers in series, five quotient bits per stage.
// The whole pipeline holds while a result waits on rsp_ready.
// Synchronous reset clears valid bits and loads register defaults; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module hdr_tone_curve_evaluator_core #(
   parameter int INPUT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [INPUT_BITS-1:0]  req_sample_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_encoded_value,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [tce_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_data
);

   localparam int XW = INPUT_BITS + 16;

   logic            adv;

   // configuration
   logic [2:0]      tone_op_ff;
   logic [15:0]     exp_gain_ff;
   logic [15:0]     white_ff;
   logic [15:0]     strength_ff;
   logic [15:0]     contrast_ff;

   // values derived from configuration
   tce_pkg::fx_type k_ff;
   tce_pkg::fx_type w_ff;
   tce_pkg::fx_type w2_ff;
   tce_pkg::fx_type hma_ff;
   tce_pkg::fx_type hmb_ff;
   tce_pkg::fx_type hnw_ff;
   tce_pkg::fx_type hdw_ff;

   logic            exp_on;
   logic            con_on;
   tce_pkg::fx_type con_fx;

   assign exp_on = (strength_ff != 16'd0);
   assign con_on = (contrast_ff != tce_pkg::CON_UNITY);
   assign con_fx = {4'd0, contrast_ff, 4'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_op_ff  <= tce_pkg::OP_LINEAR;
         exp_gain_ff <= 16'd256;
         white_ff    <= 16'd1024;
         strength_ff <= 16'd0;
         contrast_ff <= tce_pkg::CON_UNITY;
      end else if (csr_valid) begin
         unique case (csr_index)
            tce_pkg::REG_TONE_OPERATOR:   tone_op_ff  <= csr_data[2:0];
            tce_pkg::REG_EXPOSURE_GAIN:   exp_gain_ff <= csr_data;
            tce_pkg::REG_WHITE_POINT:     white_ff    <= csr_data;
            tce_pkg::REG_EXPAND_STRENGTH: strength_ff <= csr_data;
            tce_pkg::REG_CONTRAST_GAIN:   contrast_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // derived values follow a write in order: k_ff and w_ff, then w2_ff, hma_ff and hmb_ff, then hnw_ff and hdw_ff
   always_ff @(posedge clock) begin
      k_ff   <= {8'd0, (strength_ff < tce_pkg::K_EXP_MAX) ? strength_ff : tce_pkg::K_EXP_MAX};
      w_ff   <= white_ff[15] ? tce_pkg::FX_MAX : {white_ff, 8'd0};
      w2_ff  <= tce_pkg::fx_mul(w_ff, w_ff);
      hma_ff <= tce_pkg::fx_add(tce_pkg::fx_mul(tce_pkg::H_A, w_ff), tce_pkg::H_B);
      hmb_ff <= tce_pkg::fx_add(tce_pkg::fx_mul(tce_pkg::H_A, w_ff), tce_pkg::FX_HALF);
      hnw_ff <= tce_pkg::fx_add(tce_pkg::fx_mul(w_ff, hma_ff), tce_pkg::H_C);
      hdw_ff <= tce_pkg::fx_add(tce_pkg::fx_mul(w_ff, hmb_ff), tce_pkg::H_D);
   end

   // ---------------- expansion ----------------
   logic [XW-1:0]   xw;
   tce_pkg::fx_type x0;
   assign xw = {req_sample_value, 16'd0} >> INPUT_BITS;
   assign x0 = {8'd0, xw[15:0]};

   tce_pkg::fx_type x1_ff, x2_ff, kx2_ff, x3_ff, den3_ff, den3_in;
   logic            v1_ff, v2_ff, v3_ff;

   always_comb begin
      den3_in = tce_pkg::fx_add(tce_pkg::FX_ONE, 24'(-kx2_ff));
      if (den3_in < tce_pkg::DEN_MIN) den3_in = tce_pkg::DEN_MIN;
   end

   tce_pkg::fx_type q4, x4;
   logic            v4;

   tce_div #(.SIDE_W(24)) u_div_expand (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v3_ff), .in_num(x3_ff), .in_den(den3_ff), .in_side(x3_ff),
      .out_valid(v4), .out_quo(q4), .out_side(x4)
   );

   // ---------------- exposure ----------------
   tce_pkg::fx_type    xe;
   logic signed [47:0] ep;
   logic signed [47:0] eq;
   always_comb begin
      xe = exp_on ? q4 : x4;
      ep = {{24{xe[23]}}, xe} * {32'd0, exp_gain_ff};
      eq = ep >>> 8;
      if (ep[47] && (ep[7:0] != 8'd0)) eq = eq + 48'sd1;
   end

   tce_pkg::fx_type xg5_ff;
   logic            v5_ff;

   // ---------------- operator polynomials ----------------
   tce_pkg::fx_type ca, aa, cb, ab;
   always_comb begin
      if (tone_op_ff == tce_pkg::OP_HABLE) begin
         ca = tce_pkg::H_A;  aa = tce_pkg::H_B;
         cb = tce_pkg::H_A;  ab = tce_pkg::FX_HALF;
      end else begin
         ca = tce_pkg::A_A;  aa = tce_pkg::A_B;
         cb = tce_pkg::A_C;  ab = tce_pkg::A_D;
      end
   end

   tce_pkg::fx_type m6a_ff, m6b_ff, xg6_ff;
   logic            v6_ff;
   tce_pkg::fx_type n7_ff, d7_ff, xg7_ff;
   logic            v7_ff;
   logic            is_hable;
   assign is_hable = (tone_op_ff == tce_pkg::OP_HABLE);

   tce_pkg::fx_type da_num, da_den;
   assign da_num = (tone_op_ff == tce_pkg::OP_REINHARD_EX) ? xg7_ff : n7_ff;
   assign da_den = (tone_op_ff == tce_pkg::OP_REINHARD_EX) ? w2_ff : d7_ff;

   tce_pkg::fx_type qa8, qb8, n8, d8, xg8;
   logic            va8, vb8;

   tce_div #(.SIDE_W(48)) u_div_first (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v7_ff), .in_num(da_num), .in_den(da_den), .in_side({n7_ff, d7_ff}),
      .out_valid(va8), .out_quo(qa8), .out_side({n8, d8})
   );

   // Hable curve at the white point, kept in step with each word
   tce_div #(.SIDE_W(24)) u_div_white (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v7_ff), .in_num(hnw_ff), .in_den(hdw_ff), .in_side(xg7_ff),
      .out_valid(vb8), .out_quo(qb8), .out_side(xg8)
   );

   // ---------------- final division operands ----------------
   tce_pkg::fx_type a9_in, b9_in, one_x;
   logic            byp9_in;
   assign one_x = tce_pkg::fx_add(tce_pkg::FX_ONE, xg8);

   always_comb begin
      a9_in   = xg8;
      b9_in   = one_x;
      byp9_in = 1'b0;
      case (tone_op_ff)
         tce_pkg::OP_REINHARD: begin
            a9_in = xg8;
         end
         tce_pkg::OP_REINHARD_EX: begin
            a9_in = tce_pkg::fx_mul(xg8, tce_pkg::fx_add(tce_pkg::FX_ONE, qa8));
         end
         tce_pkg::OP_HABLE: begin
            a9_in = tce_pkg::fx_add(qa8, 24'(-tce_pkg::H_E));
            b9_in = tce_pkg::fx_add(qb8, 24'(-tce_pkg::H_E));
         end
         tce_pkg::OP_ACES: begin
            a9_in = n8;
            b9_in = d8;
         end
         default: begin
            byp9_in = 1'b1;
         end
      endcase
   end

   tce_pkg::fx_type a9_ff, b9_ff, xg9_ff;
   logic            byp9_ff, v9_ff;

   tce_pkg::fx_type q10, xg10;
   logic            byp10, v10;

   tce_div #(.SIDE_W(25)) u_div_final (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v9_ff), .in_num(a9_ff), .in_den(b9_ff), .in_side({byp9_ff, xg9_ff}),
      .out_valid(v10), .out_quo(q10), .out_side({byp10, xg10})
   );

   // ---------------- contrast and clamp ----------------
   tce_pkg::fx_type v_op;
   assign v_op = byp10 ? xg10 : q10;

   tce_pkg::fx_type cd11_ff, v11_ff, v12_w;
   logic            v11_vld_ff;
   logic [16:0]     s12_v_ff, s12_in;
   logic            s12_valid_ff;

   always_comb begin
      v12_w = con_on ? tce_pkg::fx_add(tce_pkg::FX_HALF, cd11_ff) : v11_ff;
      if (v12_w[23]) s12_in = 17'd0;
      else if (v12_w > tce_pkg::FX_ONE) s12_in = 17'd65536;
      else s12_in = v12_w[16:0];
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v11_vld_ff   <= 1'b0;
         s12_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v5_ff        <= v4;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v9_ff        <= va8;
         v11_vld_ff   <= v10;
         s12_valid_ff <= v11_vld_ff;
      end
      if (adv) begin
         x1_ff    <= x0;
         kx2_ff   <= tce_pkg::fx_mul(k_ff, x1_ff);
         x2_ff    <= x1_ff;
         den3_ff  <= den3_in;
         x3_ff    <= x2_ff;
         xg5_ff   <= tce_pkg::fx_sat(eq);
         m6a_ff   <= tce_pkg::fx_add(tce_pkg::fx_mul(ca, xg5_ff), aa);
         m6b_ff   <= tce_pkg::fx_add(tce_pkg::fx_mul(cb, xg5_ff), ab);
         xg6_ff   <= xg5_ff;
         n7_ff    <= tce_pkg::fx_add(tce_pkg::fx_mul(xg6_ff, m6a_ff),
                                     is_hable ? tce_pkg::H_C : tce_pkg::FX_ZERO);
         d7_ff    <= tce_pkg::fx_add(tce_pkg::fx_mul(xg6_ff, m6b_ff),
                                     is_hable ? tce_pkg::H_D : tce_pkg::A_E);
         xg7_ff   <= xg6_ff;
         a9_ff    <= a9_in;
         b9_ff    <= b9_in;
         byp9_ff  <= byp9_in;
         xg9_ff   <= xg8;
         cd11_ff  <= tce_pkg::fx_mul(tce_pkg::fx_add(v_op, 24'(-tce_pkg::FX_HALF)), con_fx);
         v11_ff   <= v_op;
         s12_v_ff <= s12_in;
      end
   end

   tce_srgb u_srgb (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s12_valid_ff), .in_level(s12_v_ff),
      .out_valid(rsp_valid), .out_code(rsp_encoded_value)
   );

   // hold every stage while the result word is refused
   assign adv       = rsp_ready | ~rsp_valid;
   assign req_ready = adv;

   `ASSERT_IMPL(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken during output stall")
   `ASSERT_IMPL(a_first_divs_aligned, clock, reset, 1'b1, va8 == vb8, "operator dividers out of step")
   `ASSERT_IMPL(a_clamp_range, clock, reset, s12_valid_ff, s12_v_ff <= 17'd65536, "clamped level above one")
   `ASSERT_NEXT(a_stall_holds_level, clock, reset, rsp_valid && !rsp_ready, $stable(s12_v_ff), "level moved during stall")

endmodule

`default_nettype wire
